// ===== rtl/wvn_pkg.sv =====
package wvn_pkg;

  // Largest window side; wider sides saturate to it
  localparam int MAX_SIDE   = 64;

  // Fixed field widths
  localparam int WORD_W     = 32;
  localparam int SIDE_W     = 7;
  localparam int STD_W      = 17;
  localparam int ROOT_W     = 16;
  localparam int SQREM_W    = 18;

  // Widths that follow from the side limit
  localparam int NM1_W      = $clog2(MAX_SIDE);
  localparam int SIDEC_W    = NM1_W + 1;
  localparam int N_W        = 2 * NM1_W;
  localparam int D_W        = 4 * NM1_W;

  // Pipeline depths
  localparam int VAR_STEPS  = 2 * WORD_W;
  localparam int MEAN_STEPS = WORD_W;
  localparam int SQRT_STEPS = ROOT_W;

  // Stream widths
  localparam int IN_DATA_W  = 168;
  localparam int OUT_DATA_W = 120;

  // Configuration register indexes
  localparam logic [7:0] CFG_VAR_FLOOR = 8'd0;
  localparam logic [7:0] CFG_STD_FLOOR = 8'd1;
  localparam logic [7:0] CFG_MEAN_LOW  = 8'd2;
  localparam logic [7:0] CFG_MEAN_HIGH = 8'd3;

  // Front stage: box sum and clamped side
  typedef struct packed {
    logic              valid;
    logic [WORD_W-1:0] sum;
    logic [WORD_W-1:0] sq;
    logic [NM1_W-1:0]  nm1;
    logic              zero;
  } f0_stage_t;

  // Pixel count and squared sum
  typedef struct packed {
    logic                valid;
    logic [WORD_W-1:0]   sum;
    logic [WORD_W-1:0]   sq;
    logic [N_W-1:0]      n;
    logic                zero;
    logic [2*WORD_W-1:0] sum2;
  } f1_stage_t;

  // Scaled square sum and divisor of the variance
  typedef struct packed {
    logic                valid;
    logic [WORD_W-1:0]   sum;
    logic [N_W-1:0]      n;
    logic                zero;
    logic [2*WORD_W-1:0] sum2;
    logic [2*WORD_W-1:0] nsq;
    logic [D_W-1:0]      d;
  } f2_stage_t;

  // One restoring division step for both quotients
  typedef struct packed {
    logic                valid;
    logic [WORD_W-1:0]   sum;
    logic [N_W-1:0]      n;
    logic [D_W-1:0]      d;
    logic                zero;
    logic [WORD_W-1:0]   mword;
    logic [N_W-1:0]      mrem;
    logic [2*WORD_W-1:0] vword;
    logic [D_W-1:0]      vrem;
  } div_stage_t;

  // One square root digit step
  typedef struct packed {
    logic               valid;
    logic [WORD_W-1:0]  sum;
    logic [WORD_W-1:0]  mean;
    logic [WORD_W-1:0]  var_q;
    logic [WORD_W-1:0]  vsh;
    logic [ROOT_W-1:0]  root;
    logic [SQREM_W-1:0] rem;
  } sq_stage_t;

endpackage

// ===== rtl/wvn_sqrt_pipe.sv =====
module wvn_sqrt_pipe (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                en,
  input  wvn_pkg::sq_stage_t  in_stage,
  output wvn_pkg::sq_stage_t  out_stage
);
  import wvn_pkg::*;

  sq_stage_t sp_r [0:SQRT_STEPS-1];

  // Take one root bit from the next two variance bits
  function automatic sq_stage_t sq_step(sq_stage_t s);
    sq_stage_t          o;
    logic [SQREM_W+1:0] r;
    logic [SQREM_W+1:0] trial;
    o     = s;
    r     = {s.rem, s.vsh[WORD_W-1 -: 2]};
    trial = {2'b00, s.root, 2'b01};
    o.vsh = {s.vsh[WORD_W-3:0], 2'b00};
    if (r >= trial) begin
      r      = r - trial;
      o.root = {s.root[ROOT_W-2:0], 1'b1};
    end else begin
      o.root = {s.root[ROOT_W-2:0], 1'b0};
    end
    o.rem = r[SQREM_W-1:0];
    return o;
  endfunction

  // Advance all digit stages together
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < SQRT_STEPS; k++) begin
        sp_r[k].valid <= 1'b0;
      end
    end else if (en) begin
      sp_r[0] <= sq_step(in_stage);
      for (int k = 1; k < SQRT_STEPS; k++) begin
        sp_r[k] <= sq_step(sp_r[k-1]);
      end
    end
  end

  assign out_stage = sp_r[SQRT_STEPS-1];

endmodule

// ===== rtl/window_variance_normalizer_top.sv =====
// Window variance normalizer.
// Input stream in_*: one item per detection window carrying the four
// integral-image corners, the window square sum and the window side.
// Output stream out_*: one item per input item, in order, carrying the box
// sum, mean, variance and rounded standard deviation; out_tuser flags a
// candidate window.
// Config channel cfg_*: always ready; index 0..3 selects variance floor,
// std floor, mean low and mean high; other indexes are ignored. Write it
// only while no item is in flight.
// Throughput: one item per cycle unless the output blocks. Stages, from
// acceptance to out_tvalid: three front stages (box sum, pixel count,
// products), 65 stages of the restoring divider (a start register, then
// one variance quotient bit a stage, mean quotient in the first 32), 16
// stages of the square root (one root bit a stage) and the output register.
// Reset clears every stage valid bit and loads the register defaults.
// When the receiver stalls, the result holds in the output register and
// the pipeline keeps accepting items until its last stage is occupied.
module window_variance_normalizer_top (
  input  logic                              clk,
  input  logic                              rst_n,
  // [31:0] top_left_sum, [63:32] top_right_sum, [95:64] bottom_left_sum,
  // [127:96] bottom_right_sum, [159:128] window_square_sum,
  // [166:160] window_side, [167] unused
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [wvn_pkg::IN_DATA_W-1:0]     in_tdata,
  // [31:0] box_sum, [63:32] mean_value, [95:64] variance,
  // [112:96] std_dev, [119:113] zero
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [wvn_pkg::OUT_DATA_W-1:0]    out_tdata,
  // [0] is_candidate
  output logic [0:0]                        out_tuser,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [7:0]                        cfg_index,
  input  logic [15:0]                       cfg_data
);
  import wvn_pkg::*;

  logic [15:0]       var_floor_r;
  logic [15:0]       std_floor_r;
  logic [7:0]        mean_low_r;
  logic [7:0]        mean_high_r;

  f0_stage_t         f0_r, f0_nxt;
  f1_stage_t         f1_r;
  f2_stage_t         f2_r;
  div_stage_t        dp_r [0:VAR_STEPS];
  div_stage_t        dp0_nxt;
  sq_stage_t         sq_in, sq_out;

  logic              out_valid_r;
  logic [OUT_DATA_W-1:0] out_data_r;
  logic              out_cand_r;
  logic              out_load;
  logic              en;

  logic [WORD_W-1:0] tl, tr, bl, br, sq;
  logic [SIDE_W-1:0] side;
  logic [SIDEC_W-1:0] side_c;

  logic [WORD_W-1:0] fin_var;
  logic [WORD_W-1:0] fin_mean;
  logic [STD_W-1:0]  fin_sd;
  logic [STD_W-1:0]  fin_root;
  logic              fin_cand;

  // Config writes
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      var_floor_r <= 16'd200;
      std_floor_r <= 16'd13;
      mean_low_r  <= 8'd30;
      mean_high_r <= 8'd200;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_VAR_FLOOR: var_floor_r <= cfg_data;
        CFG_STD_FLOOR: std_floor_r <= cfg_data;
        CFG_MEAN_LOW:  mean_low_r  <= cfg_data[7:0];
        CFG_MEAN_HIGH: mean_high_r <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // Pipeline advances unless a finished item blocks the output register
  assign out_load  = !out_valid_r || out_tready;
  assign en        = out_load || !sq_out.valid;
  assign in_tready = en;

  // Unpack input item
  assign tl   = in_tdata[31:0];
  assign tr   = in_tdata[63:32];
  assign bl   = in_tdata[95:64];
  assign br   = in_tdata[127:96];
  assign sq   = in_tdata[159:128];
  assign side = in_tdata[166:160];

  // Box sum and saturated side
  always_comb begin
    if (int'(side) > MAX_SIDE) begin
      side_c = SIDEC_W'(MAX_SIDE);
    end else begin
      side_c = SIDEC_W'(side);
    end
    f0_nxt.valid = in_tvalid;
    f0_nxt.sum   = br - tr - bl + tl;
    f0_nxt.sq    = sq;
    f0_nxt.zero  = (side_c < SIDEC_W'(2));
    f0_nxt.nm1   = NM1_W'(side_c - SIDEC_W'(1));
  end

  // Division start: numerator wraps modulo 2^64
  always_comb begin
    dp0_nxt.valid = f2_r.valid;
    dp0_nxt.sum   = f2_r.sum;
    dp0_nxt.n     = f2_r.n;
    dp0_nxt.d     = f2_r.d;
    dp0_nxt.zero  = f2_r.zero;
    dp0_nxt.mword = f2_r.sum;
    dp0_nxt.mrem  = '0;
    dp0_nxt.vword = f2_r.nsq - f2_r.sum2;
    dp0_nxt.vrem  = '0;
  end

  // One quotient bit of variance, and of mean in the early steps
  function automatic div_stage_t div_step(div_stage_t s, int k);
    div_stage_t   o;
    logic [D_W:0] vr;
    logic [N_W:0] mr;
    o       = s;
    vr      = {s.vrem, s.vword[2*WORD_W-1]};
    o.vword = {s.vword[2*WORD_W-2:0], 1'b0};
    if (vr >= {1'b0, s.d}) begin
      vr         = vr - {1'b0, s.d};
      o.vword[0] = 1'b1;
    end
    o.vrem = vr[D_W-1:0];
    if (k < MEAN_STEPS) begin
      mr      = {s.mrem, s.mword[WORD_W-1]};
      o.mword = {s.mword[WORD_W-2:0], 1'b0};
      if (mr >= {1'b0, s.n}) begin
        mr         = mr - {1'b0, s.n};
        o.mword[0] = 1'b1;
      end
      o.mrem = mr[N_W-1:0];
    end
    return o;
  endfunction

  // Front stages and divider stages
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f0_r.valid <= 1'b0;
      f1_r.valid <= 1'b0;
      f2_r.valid <= 1'b0;
      for (int k = 0; k <= VAR_STEPS; k++) begin
        dp_r[k].valid <= 1'b0;
      end
    end else if (en) begin
      f0_r <= f0_nxt;

      f1_r.valid <= f0_r.valid;
      f1_r.sum   <= f0_r.sum;
      f1_r.sq    <= f0_r.sq;
      f1_r.zero  <= f0_r.zero;
      f1_r.n     <= N_W'(f0_r.nm1) * N_W'(f0_r.nm1);
      f1_r.sum2  <= (2*WORD_W)'(f0_r.sum) * (2*WORD_W)'(f0_r.sum);

      f2_r.valid <= f1_r.valid;
      f2_r.sum   <= f1_r.sum;
      f2_r.n     <= f1_r.n;
      f2_r.zero  <= f1_r.zero;
      f2_r.sum2  <= f1_r.sum2;
      f2_r.nsq   <= (2*WORD_W)'(f1_r.n) * (2*WORD_W)'(f1_r.sq);
      f2_r.d     <= D_W'(f1_r.n) * D_W'(f1_r.n);

      dp_r[0] <= dp0_nxt;
      for (int k = 1; k <= VAR_STEPS; k++) begin
        dp_r[k] <= div_step(dp_r[k-1], k - 1);
      end
    end
  end

  // Quotients, zero when the window side is below 2
  always_comb begin
    fin_var  = dp_r[VAR_STEPS].zero ? '0 : dp_r[VAR_STEPS].vword[WORD_W-1:0];
    fin_mean = dp_r[VAR_STEPS].zero ? '0 : dp_r[VAR_STEPS].mword;
    sq_in.valid = dp_r[VAR_STEPS].valid;
    sq_in.sum   = dp_r[VAR_STEPS].sum;
    sq_in.mean  = fin_mean;
    sq_in.var_q = fin_var;
    sq_in.vsh   = fin_var;
    sq_in.root  = '0;
    sq_in.rem   = '0;
  end

  wvn_sqrt_pipe u_sqrt (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_stage  (sq_in),
    .out_stage (sq_out)
  );

  // Round the root, apply the floor, test the window
  always_comb begin
    fin_root = STD_W'(sq_out.root);
    if (sq_out.var_q < WORD_W'(var_floor_r)) begin
      fin_sd = STD_W'(1);
    end else if (sq_out.rem > SQREM_W'(sq_out.root)) begin
      fin_sd = fin_root + STD_W'(1);
    end else begin
      fin_sd = fin_root;
    end
    if (fin_sd == '0) begin
      fin_sd = STD_W'(1);
    end
    fin_cand = (fin_sd > STD_W'(std_floor_r)) &&
               (sq_out.mean > WORD_W'(mean_low_r)) &&
               (sq_out.mean < WORD_W'(mean_high_r));
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= sq_out.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data_r <= {7'd0, fin_sd, sq_out.var_q, sq_out.mean, sq_out.sum};
      out_cand_r <= fin_cand;
    end
  end

  assign out_tvalid   = out_valid_r;
  assign out_tdata    = out_data_r;
  assign out_tuser[0] = out_cand_r;

  // Standard deviation is never zero on a delivered item
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[112:96] != '0)
    else $error("std_dev of zero delivered");

  // A candidate always clears the std floor
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser[0]) |-> out_tdata[112:96] > STD_W'(std_floor_r))
    else $error("candidate below std floor");

  // Input stalls only behind a blocked output
  assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> (out_tvalid && !out_tready))
    else $error("input stalled without output back-pressure");

  // Nothing is delivered right after reset
  assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("output valid after reset");

endmodule
